>>> rtl/lrsf_pkg.sv
package lrsf_pkg;

  localparam int COEF_W     = 24;
  localparam int HIST_W     = 32;
  localparam int SAMPLE_W   = 16;
  localparam int EXC_W      = 16;
  localparam int PE_W       = 16;
  localparam int WORD_W     = 16;
  localparam int BYTE_W     = 8;
  localparam int IDX_W      = 5;
  localparam int COEF_SLOTS = 32;
  localparam int COEF_AW    = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Magnitude offsets of the eight mu-law segments.
  localparam logic [14:0] MU_TABLE [8] = '{
    15'd0, 15'd132, 15'd396, 15'd924, 15'd1980, 15'd4092, 15'd8316, 15'd16764
  };

  typedef struct packed {
    logic                    start;
    logic signed [EXC_W-1:0] exc;
    logic                    tap;
    logic                    tap_hi;
    logic                    fin_y;
    logic                    fin_sum;
    logic                    commit;
  } mac_ctrl_t;

  typedef struct packed {
    logic                       busy;
    logic signed [HIST_W-1:0]   y;
    logic signed [SAMPLE_W-1:0] sample;
  } mac_stat_t;

  function automatic logic signed [EXC_W-1:0] mulaw_decode(input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] u;
    logic [2:0]        e;
    logic [3:0]        m;
    logic [EXC_W-1:0]  mag;
    u   = ~b;
    e   = u[6:4];
    m   = u[3:0];
    mag = EXC_W'(MU_TABLE[e]) + (EXC_W'(m) << ({1'b0, e} + 4'd3));
    return u[7] ? -$signed(mag) : $signed(mag);
  endfunction

endpackage

>>> rtl/lpc_residual_synthesis_filter.sv
// All-pole LPC synthesis filter driven by a mu-law coded residual.
//
// Input channel (in_valid_i / in_stall_o): each transaction is a command.
// A load command unpacks coef_word_i into the Q5.18 coefficient of tap
// coef_index_i; it returns no output and holds the input until the
// coefficient is written. A process command decodes residual_byte_i and
// runs the filter once per use of the byte, as many uses as the fold
// register asks, giving one output transaction (sample_o, last_o) per run,
// with last_o set on the final one. Each run reads the coefficient and
// history memories once per tap, then passes through the multiplier and
// accumulator pipeline and the output arithmetic. The input is stalled
// while a command is in hand. When the receiver stalls the output, the
// finished sample waits in the output register and the next run stops just
// before it would overwrite it. Reset empties both memories (valid bits
// clear at once, no clearing pass), zeroes the write position and previous
// output and loads the register defaults, an order of 16 among them. The
// user must see that registers are written through cfg_we_i only while
// idle; the block itself does not enforce it.
module lpc_residual_synthesis_filter #(
  parameter int MAX_ORDER = 32,
  parameter int MAX_FOLD  = 8
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [lrsf_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [lrsf_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 command_i,
  input  logic [lrsf_pkg::IDX_W-1:0]           coef_index_i,
  input  logic [lrsf_pkg::WORD_W-1:0]          coef_word_i,
  input  logic [lrsf_pkg::BYTE_W-1:0]          residual_byte_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [lrsf_pkg::SAMPLE_W-1:0] sample_o,
  output logic                                 last_o
);
  import lrsf_pkg::*;

  localparam int POS_W  = $clog2(MAX_ORDER + 1);
  localparam int FOLD_W = $clog2(MAX_FOLD + 1);

  typedef enum logic [2:0] {
    REG_ORDER, REG_COEF_MIN, REG_COEF_RANGE, REG_FOLD, REG_POST_EMPH, REG_CLEAR
  } cfg_reg_e;

  typedef enum logic {CMD_LOAD, CMD_PROC} cmd_e;

  typedef enum logic [2:0] {
    S_IDLE, S_LOAD, S_START, S_MAC, S_DRAIN, S_Y, S_SUM, S_OUT
  } state_e;

  // Configuration registers.
  logic [5:0]               cfg_order_q;
  logic signed [COEF_W-1:0] cfg_min_q;
  logic signed [COEF_W-1:0] cfg_range_q;
  logic [3:0]               cfg_fold_q;
  logic signed [PE_W-1:0]   cfg_pe_q;
  logic                     cfg_clear_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_order_q <= 6'd16;
      cfg_min_q   <= '0;
      cfg_range_q <= '0;
      cfg_fold_q  <= 4'd1;
      cfg_pe_q    <= '0;
      cfg_clear_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_ORDER:      cfg_order_q <= cfg_data_i[5:0];
        REG_COEF_MIN:   cfg_min_q   <= cfg_data_i[COEF_W-1:0];
        REG_COEF_RANGE: cfg_range_q <= cfg_data_i[COEF_W-1:0];
        REG_FOLD:       cfg_fold_q  <= cfg_data_i[3:0];
        REG_POST_EMPH:  cfg_pe_q    <= cfg_data_i[PE_W-1:0];
        REG_CLEAR:      cfg_clear_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Out-of-range order and fold settings are clamped into the legal range.
  logic [POS_W-1:0]  order_eff;
  logic [FOLD_W-1:0] fold_eff;

  always_comb begin
    if (cfg_order_q == '0) begin
      order_eff = POS_W'(1);
    end else if (32'(cfg_order_q) > 32'(MAX_ORDER)) begin
      order_eff = POS_W'(MAX_ORDER);
    end else begin
      order_eff = POS_W'(cfg_order_q);
    end
    if (cfg_fold_q == '0) begin
      fold_eff = FOLD_W'(1);
    end else if (32'(cfg_fold_q) > 32'(MAX_FOLD)) begin
      fold_eff = FOLD_W'(MAX_FOLD);
    end else begin
      fold_eff = FOLD_W'(cfg_fold_q);
    end
  end

  state_e                     state_q;
  logic [IDX_W-1:0]           idx_q;
  logic signed [EXC_W-1:0]    exc_q;
  logic [POS_W-1:0]           wp_q, k_q, cr_q;
  logic [FOLD_W-1:0]          n_q;
  logic                       out_vld_q, out_last_q;
  logic signed [SAMPLE_W-1:0] out_sample_q;

  logic             slot_free, last_n;
  logic             unp_done;
  logic [COEF_W-1:0] unp_coef;
  logic             coef_we, hist_we, hist_clr;
  logic [COEF_W-1:0] coef_rd;
  logic [HIST_W-1:0] hist_rd;
  mac_ctrl_t        mac_ctrl;
  mac_stat_t        mac_stat;

  assign in_stall_o = (state_q != S_IDLE);
  assign slot_free  = !out_vld_q || !out_stall_i;
  assign last_n     = (n_q == fold_eff - FOLD_W'(1));

  // A finished coefficient is written when the unpacker delivers it; loading
  // tap zero in clear mode also empties the history ring.
  assign coef_we  = (state_q == S_LOAD) && unp_done;
  assign hist_clr = coef_we && (idx_q == '0) && cfg_clear_q;
  // The filter output is written back to the ring as the sample is issued.
  assign hist_we  = (state_q == S_OUT) && slot_free;

  always_comb begin
    mac_ctrl.start   = (state_q == S_START);
    mac_ctrl.exc     = exc_q;
    mac_ctrl.tap     = (state_q == S_MAC);
    mac_ctrl.tap_hi  = (32'(k_q) >= 32'(COEF_SLOTS));
    mac_ctrl.fin_y   = (state_q == S_Y);
    mac_ctrl.fin_sum = (state_q == S_SUM);
    mac_ctrl.commit  = hist_we;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      idx_q        <= '0;
      exc_q        <= '0;
      wp_q         <= '0;
      k_q          <= '0;
      cr_q         <= '0;
      n_q          <= '0;
      out_vld_q    <= 1'b0;
      out_last_q   <= 1'b0;
      out_sample_q <= '0;
    end else begin
      // The output register fills as a sample is issued and empties once the
      // receiver takes it.
      if (hist_we) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            if (cmd_e'(command_i) == CMD_LOAD) begin
              idx_q   <= coef_index_i;
              state_q <= S_LOAD;
            end else begin
              exc_q <= mulaw_decode(residual_byte_i);
              n_q   <= '0;
              // The order may have been lowered below the write position.
              if (wp_q > order_eff) begin
                wp_q <= '0;
              end
              state_q <= S_START;
            end
          end
        end
        S_LOAD: begin
          if (unp_done) begin
            state_q <= S_IDLE;
          end
        end
        S_START: begin
          k_q     <= '0;
          cr_q    <= (wp_q == '0) ? order_eff : wp_q - POS_W'(1);
          state_q <= S_MAC;
        end
        S_MAC: begin
          k_q  <= k_q + POS_W'(1);
          cr_q <= (cr_q == '0) ? order_eff : cr_q - POS_W'(1);
          if (k_q == order_eff - POS_W'(1)) begin
            state_q <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!mac_stat.busy) begin
            state_q <= S_Y;
          end
        end
        S_Y: begin
          state_q <= S_SUM;
        end
        S_SUM: begin
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (slot_free) begin
            out_sample_q <= mac_stat.sample;
            out_last_q   <= last_n;
            wp_q         <= (wp_q == order_eff) ? '0 : wp_q + POS_W'(1);
            n_q          <= n_q + FOLD_W'(1);
            state_q      <= last_n ? S_IDLE : S_START;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  lrsf_unpack u_unpack (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_valid_i && !in_stall_o && (cmd_e'(command_i) == CMD_LOAD)),
    .word_i  (coef_word_i),
    .range_i (cfg_range_q),
    .min_i   (cfg_min_q),
    .done_o  (unp_done),
    .coef_o  (unp_coef)
  );

  lrsf_vram #(
    .DEPTH (COEF_SLOTS),
    .WIDTH (COEF_W)
  ) u_coef_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clr_i   (1'b0),
    .we_i    (coef_we),
    .waddr_i (idx_q),
    .wdata_i (unp_coef),
    .re_i    (mac_ctrl.tap),
    .raddr_i (COEF_AW'(k_q)),
    .rdata_o (coef_rd)
  );

  lrsf_vram #(
    .DEPTH (MAX_ORDER + 1),
    .WIDTH (HIST_W)
  ) u_hist_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clr_i   (hist_clr),
    .we_i    (hist_we),
    .waddr_i (wp_q),
    .wdata_i (mac_stat.y),
    .re_i    (mac_ctrl.tap),
    .raddr_i (cr_q),
    .rdata_o (hist_rd)
  );

  lrsf_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .pe_i   (cfg_pe_q),
    .coef_i (coef_rd),
    .hist_i (hist_rd),
    .stat_o (mac_stat)
  );

  assign out_valid_o = out_vld_q;
  assign sample_o    = out_sample_q;
  assign last_o      = out_last_q;

  // The accumulator pipeline only carries taps while the tap pass is running
  // or draining.
  a_mac_busy_scope: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mac_stat.busy |-> (state_q == S_MAC || state_q == S_DRAIN))
    else $error("accumulator pipeline active outside the tap pass");

  // A finished coefficient only arrives while a load is outstanding.
  a_unpack_done_scope: assert property (@(posedge clk_i) disable iff (!rst_ni)
    unp_done |-> (state_q == S_LOAD))
    else $error("coefficient delivered with no load outstanding");

  // The write position always addresses an entry of the history ring.
  a_wp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(wp_q) <= 32'(MAX_ORDER))
    else $error("history write position outside the ring");

  // Issuing the final sample of a residual byte frees the input.
  a_last_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hist_we && last_n) |=> (state_q == S_IDLE && out_vld_q && out_last_q))
    else $error("final sample did not return the block to idle");

endmodule

>>> rtl/lrsf_vram.sv
module lrsf_vram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             clr_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [DEPTH-1:0] vld_q;
  logic [WIDTH-1:0] rdata_q;
  logic             rvld_q;

  // An entry that has not been written since reset or the last clear reads as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (clr_i) begin
        vld_q <= '0;
      end else if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rvld_q <= vld_q[raddr_i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rvld_q ? rdata_q : '0;

endmodule

>>> rtl/lrsf_unpack.sv
module lrsf_unpack (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [lrsf_pkg::WORD_W-1:0]        word_i,
  input  logic signed [lrsf_pkg::COEF_W-1:0] range_i,
  input  logic signed [lrsf_pkg::COEF_W-1:0] min_i,
  output logic                               done_o,
  output logic [lrsf_pkg::COEF_W-1:0]        coef_o
);
  import lrsf_pkg::*;

  localparam int P_W = WORD_W + COEF_W;
  localparam int Q_W = COEF_W + 1;
  localparam int T_W = COEF_W + 2;
  localparam logic signed [T_W-1:0] C_MAX = T_W'((1 <<< (COEF_W - 1)) - 1);
  localparam logic signed [T_W-1:0] C_MIN = T_W'(-(1 <<< (COEF_W - 1)));

  logic [3:0]              vld_q;
  logic                    neg1_q, neg2_q;
  logic [P_W-1:0]          prod1_q;
  logic [COEF_W-1:0]       q0_q;
  logic [Q_W-1:0]          r0_q;
  logic signed [T_W-1:0]   t_q;
  logic [COEF_W-1:0]       coef_q;

  logic [COEF_W-1:0]       mag;
  logic [8:0]              q1;
  logic [16:0]             r1, r2;
  logic                    c1, corr;
  logic [Q_W-1:0]          quo;
  logic signed [T_W-1:0]   sum;

  always_comb begin
    mag  = range_i[COEF_W-1] ? COEF_W'(-range_i) : COEF_W'(range_i);
    // Division by 65535: fold the high half back onto the low half until
    // the remainder is below the divisor.
    q1   = r0_q[Q_W-1:16];
    r1   = 17'(r0_q[15:0]) + 17'(q1);
    c1   = r1[16];
    r2   = 17'(r1[15:0]) + 17'(c1);
    corr = (r2 == 17'd65535);
    quo  = Q_W'(q0_q) + Q_W'(q1) + Q_W'(c1) + Q_W'(corr);
    sum  = t_q + T_W'(min_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[2:0], start_i};
    end
  end

  always_ff @(posedge clk_i) begin
    neg1_q  <= range_i[COEF_W-1];
    prod1_q <= P_W'(word_i) * P_W'(mag);
    neg2_q  <= neg1_q;
    q0_q    <= prod1_q[P_W-1:16];
    r0_q    <= Q_W'(prod1_q[15:0]) + Q_W'(prod1_q[P_W-1:16]);
    t_q     <= neg2_q ? -$signed(T_W'(quo)) : $signed(T_W'(quo));
    if (sum > C_MAX) begin
      coef_q <= COEF_W'(C_MAX);
    end else if (sum < C_MIN) begin
      coef_q <= COEF_W'(C_MIN);
    end else begin
      coef_q <= COEF_W'(sum);
    end
  end

  assign done_o = vld_q[3];
  assign coef_o = coef_q;

endmodule

>>> rtl/lrsf_mac.sv
module lrsf_mac (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  lrsf_pkg::mac_ctrl_t                ctrl_i,
  input  logic signed [lrsf_pkg::PE_W-1:0]   pe_i,
  input  logic signed [lrsf_pkg::COEF_W-1:0] coef_i,
  input  logic signed [lrsf_pkg::HIST_W-1:0] hist_i,
  output lrsf_pkg::mac_stat_t                stat_o
);
  import lrsf_pkg::*;

  localparam int ACC_W  = 64;
  localparam int PROD_W = COEF_W + HIST_W;
  localparam int PEP_W  = HIST_W + PE_W;
  localparam int SUM_W  = PEP_W + 1;
  localparam int EXC_SH = 26;
  localparam int Y_SH   = 18;
  localparam int S_SH   = 22;
  localparam int P_SH   = 14;
  localparam logic signed [ACC_W-1:0] Y_MAX = {{(ACC_W-HIST_W+1){1'b0}}, {(HIST_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] Y_MIN = {{(ACC_W-HIST_W+1){1'b1}}, {(HIST_W-1){1'b0}}};
  localparam logic signed [SUM_W-1:0] S_RND = SUM_W'((1 <<< S_SH) - 1);
  localparam logic signed [SUM_W-1:0] S_MAX = SUM_W'((1 <<< (SAMPLE_W - 1)) - 1);
  localparam logic signed [SUM_W-1:0] S_MIN = SUM_W'(-(1 <<< (SAMPLE_W - 1)));

  logic                     t1_q, t2_q, hi1_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [PEP_W-1:0]  pep_q;
  logic signed [HIST_W-1:0] y_q, prev_q;
  logic signed [SUM_W-1:0]  sum_q;

  logic signed [ACC_W-1:0]    acc_sh;
  logic signed [SUM_W-1:0]    rnd, shq;
  logic signed [SAMPLE_W-1:0] sample;

  always_comb begin
    acc_sh = acc_q >>> Y_SH;
    rnd    = sum_q[SUM_W-1] ? sum_q + S_RND : sum_q;
    shq    = rnd >>> S_SH;
    if (shq > S_MAX) begin
      sample = SAMPLE_W'(S_MAX);
    end else if (shq < S_MIN) begin
      sample = SAMPLE_W'(S_MIN);
    end else begin
      sample = SAMPLE_W'(shq);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t1_q   <= 1'b0;
      t2_q   <= 1'b0;
      hi1_q  <= 1'b0;
      prev_q <= '0;
    end else begin
      t1_q  <= ctrl_i.tap;
      t2_q  <= t1_q;
      hi1_q <= ctrl_i.tap_hi;
      if (ctrl_i.commit) begin
        prev_q <= y_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    // Taps beyond the coefficient store contribute nothing.
    prod_q <= hi1_q ? '0 : PROD_W'(coef_i) * PROD_W'(hist_i);
    if (ctrl_i.start) begin
      acc_q <= ACC_W'($signed(ctrl_i.exc)) <<< EXC_SH;
      pep_q <= PEP_W'(prev_q) * PEP_W'(pe_i);
    end else if (t2_q) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
    if (ctrl_i.fin_y) begin
      if (acc_sh > Y_MAX) begin
        y_q <= HIST_W'(Y_MAX);
      end else if (acc_sh < Y_MIN) begin
        y_q <= HIST_W'(Y_MIN);
      end else begin
        y_q <= HIST_W'(acc_sh);
      end
    end
    if (ctrl_i.fin_sum) begin
      sum_q <= (SUM_W'(y_q) <<< P_SH) + SUM_W'(pep_q);
    end
  end

  assign stat_o.busy   = t1_q | t2_q;
  assign stat_o.y      = y_q;
  assign stat_o.sample = sample;

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps

module testbench;

  import lrsf_pkg::*;

  localparam int MAX_ORDER    = 32;
  localparam int MAX_FOLD     = 8;
  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 41;
  localparam int SETTLE_WAIT  = 24;
  localparam int HOLD_CYCLES  = 320;
  localparam int REPORT_LIMIT = 10;

  // Register map of the configuration port, in the order the block defines it.
  // The two top indexes are unused and any write to them must be ignored.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORDER,
    REG_COEF_MIN,
    REG_COEF_RANGE,
    REG_FOLD,
    REG_EMPHASIS,
    REG_CLEAR,
    REG_SPARE_6,
    REG_SPARE_7
  } reg_sel_e;

  typedef enum logic {
    CMD_LOAD    = 1'b0,
    CMD_PROCESS = 1'b1
  } cmd_e;

  typedef enum logic {
    ROW_CFG,
    ROW_ITEM
  } row_kind_e;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } pcm_t;

  // One line of the directed script: either a register write or a command
  // transaction, optionally with the sample typed in by hand.
  typedef struct packed {
    row_kind_e                  kind;
    reg_sel_e                   sel;
    logic [CFG_DATA_W-1:0]      data;
    cmd_e                       cmd;
    logic [IDX_W-1:0]           idx;
    logic [WORD_W-1:0]          word;
    logic [BYTE_W-1:0]          code;
    logic                       typed;
    logic signed [SAMPLE_W-1:0] want;
  } script_row_t;

  logic                       clk_i;
  logic                       rst_ni          = 1'b0;
  logic                       cfg_we_i        = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_idx_i       = '0;
  logic [CFG_DATA_W-1:0]      cfg_data_i      = '0;
  logic                       in_valid_i      = 1'b0;
  logic                       in_stall_o;
  logic                       command_i       = 1'b0;
  logic [IDX_W-1:0]           coef_index_i    = '0;
  logic [WORD_W-1:0]          coef_word_i     = '0;
  logic [BYTE_W-1:0]          residual_byte_i = '0;
  logic                       out_valid_o;
  logic                       out_stall_i     = 1'b0;
  logic signed [SAMPLE_W-1:0] sample_o;
  logic                       last_o;

  // Shared control between the stimulus and the sample sink.
  logic quiet        = 1'b0;
  logic hold_request = 1'b0;
  int   hold_left    = 0;

  int fault_count      = 0;
  int samples_checked  = 0;
  int loads_sent       = 0;
  int bytes_sent       = 0;
  int settings_written = 0;

  // Predictor state: a private copy of the registers and of the filter memories.
  logic [5:0]               order_reg;
  logic signed [COEF_W-1:0] cmin_reg;
  logic signed [COEF_W-1:0] crange_reg;
  logic [3:0]               fold_reg;
  logic signed [PE_W-1:0]   emph_reg;
  logic                     clear_reg;
  logic signed [COEF_W-1:0] tap_coef [COEF_SLOTS];
  logic signed [HIST_W-1:0] ring [MAX_ORDER+1];
  int unsigned              ring_wr;
  logic signed [HIST_W-1:0] last_y;

  pcm_t        pcm_expected [$];
  script_row_t script [$];

  lpc_residual_synthesis_filter #(
    .MAX_ORDER(MAX_ORDER),
    .MAX_FOLD (MAX_FOLD)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .command_i      (command_i),
    .coef_index_i   (coef_index_i),
    .coef_word_i    (coef_word_i),
    .residual_byte_i(residual_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .sample_o       (sample_o),
    .last_o         (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Watchdog: a correct run finishes far inside this bound, even with every
  // byte at full order and fold and the sink stalling at random throughout.
  initial begin
    #3_000_000;
    $display("simulation failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic void clear_model();
    order_reg  = 6'd16;
    cmin_reg   = '0;
    crange_reg = '0;
    fold_reg   = 4'd1;
    emph_reg   = '0;
    clear_reg  = 1'b0;
    for (int k = 0; k < COEF_SLOTS; k++) tap_coef[k] = '0;
    for (int k = 0; k <= MAX_ORDER; k++) ring[k] = '0;
    ring_wr = 0;
    last_y  = '0;
  endfunction

  function automatic void program_register(input reg_sel_e sel,
                                           input logic [CFG_DATA_W-1:0] data);
    case (sel)
      REG_ORDER:      order_reg  = data[5:0];
      REG_COEF_MIN:   cmin_reg   = data[COEF_W-1:0];
      REG_COEF_RANGE: crange_reg = data[COEF_W-1:0];
      REG_FOLD:       fold_reg   = data[3:0];
      REG_EMPHASIS:   emph_reg   = data[PE_W-1:0];
      REG_CLEAR:      clear_reg  = data[0];
      default:        ;
    endcase
  endfunction

  // An order of zero behaves as one tap, anything above MAX_ORDER as MAX_ORDER taps.
  function automatic int unsigned taps_in_use();
    if (order_reg == 0) return 1;
    if (order_reg > MAX_ORDER) return MAX_ORDER;
    return order_reg;
  endfunction

  function automatic int expand_mulaw(input logic [BYTE_W-1:0] code);
    logic [BYTE_W-1:0] inv;
    int                seg;
    int                base;
    int                mag;
    inv = ~code;
    seg = inv[6:4];
    case (seg)
      0:       base = 0;
      1:       base = 132;
      2:       base = 396;
      3:       base = 924;
      4:       base = 1980;
      5:       base = 4092;
      6:       base = 8316;
      default: base = 16764;
    endcase
    mag = base + (int'(inv[3:0]) << (seg + 3));
    return inv[7] ? -mag : mag;
  endfunction

  // Scale the packed word into the coefficient span, offset it and saturate.
  function automatic void unpack_coefficient(input logic [IDX_W-1:0] idx,
                                             input logic [WORD_W-1:0] word);
    longint t;
    t = (longint'(word) * longint'(crange_reg)) / 65535 + longint'(cmin_reg);
    if (t > 64'sd8388607) t = 64'sd8388607;
    else if (t < -64'sd8388608) t = -64'sd8388608;
    if (idx == 0 && clear_reg) begin
      for (int k = 0; k <= MAX_ORDER; k++) ring[k] = '0;
    end
    tap_coef[idx] = t[COEF_W-1:0];
  endfunction

  // Run the filter once per use of the excitation and queue each sample.
  function automatic void synthesise_byte(input logic [BYTE_W-1:0] code);
    int unsigned ord;
    int unsigned uses;
    int unsigned rd;
    longint      exc;
    longint      acc;
    longint      yv;
    longint      sv;
    pcm_t        p;
    ord  = taps_in_use();
    uses = (fold_reg == 0) ? 1 : ((fold_reg > MAX_FOLD) ? MAX_FOLD : fold_reg);
    exc  = longint'(expand_mulaw(code)) * (longint'(1) << 26);
    if (ring_wr > ord) ring_wr = 0;
    for (int unsigned n = 0; n < uses; n++) begin
      acc = exc;
      rd  = (ring_wr == 0) ? ord : ring_wr - 1;
      for (int unsigned k = 0; k < ord; k++) begin
        acc += longint'(tap_coef[k]) * longint'(ring[rd]);
        rd = (rd == 0) ? ord : rd - 1;
      end
      yv = acc >>> 18;
      if (yv > 64'sd2147483647) yv = 64'sd2147483647;
      else if (yv < -64'sd2147483648) yv = -64'sd2147483648;
      sv = (yv * 16384 + longint'(last_y) * longint'(emph_reg)) / (longint'(1) << 22);
      if (sv > 64'sd32767) sv = 64'sd32767;
      else if (sv < -64'sd32768) sv = -64'sd32768;
      last_y        = yv[HIST_W-1:0];
      ring[ring_wr] = yv[HIST_W-1:0];
      ring_wr       = (ring_wr == ord) ? 0 : ring_wr + 1;
      p.sample = sv[SAMPLE_W-1:0];
      p.last   = (n + 1 == uses);
      pcm_expected.push_back(p);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Directed script helpers
  // ---------------------------------------------------------------------------

  function automatic script_row_t cfg_row(input reg_sel_e sel,
                                          input logic [CFG_DATA_W-1:0] data);
    script_row_t r;
    r      = '0;
    r.kind = ROW_CFG;
    r.sel  = sel;
    r.data = data;
    return r;
  endfunction

  function automatic script_row_t item_row(input cmd_e cmd, input logic [IDX_W-1:0] idx,
                                           input logic [WORD_W-1:0] word,
                                           input logic [BYTE_W-1:0] code);
    script_row_t r;
    r      = '0;
    r.kind = ROW_ITEM;
    r.cmd  = cmd;
    r.idx  = idx;
    r.word = word;
    r.code = code;
    return r;
  endfunction

  function automatic script_row_t typed_row(input logic [BYTE_W-1:0] code,
                                            input logic signed [SAMPLE_W-1:0] want);
    script_row_t r;
    r       = item_row(CMD_PROCESS, '0, '0, code);
    r.typed = 1'b1;
    r.want  = want;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Offer one command transaction and update the predictor once it is taken.
  // The payload is held steady while the block stalls; a random gap may come
  // before the transaction unless the quiet stretch is running.
  task automatic offer(input cmd_e cmd, input logic [IDX_W-1:0] idx,
                       input logic [WORD_W-1:0] word, input logic [BYTE_W-1:0] code);
    if (!quiet && $urandom_range(0, 99) < 21) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    command_i       <= cmd;
    coef_index_i    <= idx;
    coef_word_i     <= word;
    residual_byte_i <= code;
    do @(posedge clk_i); while (in_stall_o);
    if (cmd == CMD_LOAD) begin
      unpack_coefficient(idx, word);
      loads_sent++;
    end else begin
      synthesise_byte(code);
      bytes_sent++;
    end
  endtask

  // Drop the input, let every queued sample drain, then give a load command
  // (which returns nothing) time to finish before the block counts as idle.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pcm_expected.size() != 0) @(posedge clk_i);
    repeat (SETTLE_WAIT) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_sel_e sel, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= sel;
    cfg_data_i <= data;
    @(posedge clk_i);
    program_register(sel, data);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    settings_written++;
  endtask

  task automatic note_fault(input string msg);
    fault_count++;
    if (fault_count <= REPORT_LIMIT) $display("%t: %s", $realtime, msg);
  endtask

  task automatic take_sample();
    pcm_t want;
    if (pcm_expected.size() == 0) begin
      note_fault($sformatf("sample %0d last %0b arrived with nothing outstanding",
                           sample_o, last_o));
      return;
    end
    want = pcm_expected.pop_front();
    samples_checked++;
    if (sample_o !== want.sample || last_o !== want.last) begin
      note_fault($sformatf("sample mismatch: expected %0d last %0b, got %0d last %0b",
                           $signed(want.sample), want.last, sample_o, last_o));
    end
  endtask

  // Sample sink: checks each accepted output transaction against the oldest
  // expectation, then chooses the stall for the next cycle. A hold-off request
  // stalls the output for a long stretch so that the block backs up and
  // stalls its own input while the stimulus keeps offering commands.
  initial begin
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) take_sample();
      if (hold_request) begin
        hold_left    = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !quiet && ($urandom_range(0, 99) < 21);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  initial begin
    int                    sent;
    int                    ntaps;
    int                    nbytes;
    logic [5:0]            ord;
    logic [3:0]            fld;
    logic [CFG_DATA_W-1:0] cmin;
    logic [CFG_DATA_W-1:0] crange;
    script_row_t           row;
    pcm_t                  held;

    clear_model();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Straight after reset every coefficient is zero and emphasis is off, so
    // a single-use byte gives exactly its decoded mu-law value.
    script.push_back(typed_row(8'hFF, 16'sd0));
    script.push_back(typed_row(8'h80, 16'sd32124));
    script.push_back(typed_row(8'h00, -16'sd32124));
    script.push_back(typed_row(8'h7F, 16'sd0));
    script.push_back(typed_row(8'h7E, -16'sd8));
    script.push_back(typed_row(8'h8F, 16'sd16764));
    // Largest offset with the most negative span: word 0 gives full scale on
    // tap 0, word 65535 gives minus one on tap 31, the last tap.
    script.push_back(cfg_row(REG_COEF_MIN, 24'h7FFFFF));
    script.push_back(cfg_row(REG_COEF_RANGE, 24'h800000));
    script.push_back(item_row(CMD_LOAD, 5'd0, 16'h0000, 8'h00));
    script.push_back(item_row(CMD_LOAD, 5'd31, 16'hFFFF, 8'hFF));
    // Order zero behaves as one tap; the write position now lies beyond the
    // ring and has to restart, and the history runs into saturation.
    script.push_back(cfg_row(REG_ORDER, 24'd0));
    script.push_back(cfg_row(REG_FOLD, 24'd0));
    script.push_back(item_row(CMD_PROCESS, 5'd0, 16'h0000, 8'h80));
    script.push_back(item_row(CMD_PROCESS, 5'd0, 16'h0000, 8'h80));
    script.push_back(cfg_row(REG_EMPHASIS, 24'h008000));
    script.push_back(item_row(CMD_PROCESS, 5'd0, 16'h0000, 8'h00));
    script.push_back(cfg_row(REG_EMPHASIS, 24'h007FFF));
    // A fold above the limit behaves as the limit, as does an order above it.
    script.push_back(cfg_row(REG_FOLD, 24'h00000F));
    script.push_back(item_row(CMD_PROCESS, 5'd0, 16'h0000, 8'h80));
    script.push_back(cfg_row(REG_ORDER, 24'h00003F));
    script.push_back(cfg_row(REG_CLEAR, 24'd1));
    script.push_back(item_row(CMD_LOAD, 5'd0, 16'hFFFF, 8'h00));
    script.push_back(cfg_row(REG_SPARE_6, 24'hFFFFFF));
    script.push_back(cfg_row(REG_SPARE_7, 24'hFFFFFF));
    script.push_back(item_row(CMD_PROCESS, 5'd0, 16'h0000, 8'h55));
    script.push_back(item_row(CMD_LOAD, 5'd5, 16'h8000, 8'h00));
    script.push_back(item_row(CMD_PROCESS, 5'd0, 16'h0000, 8'h2A));

    for (int i = 0; i < script.size(); i++) begin
      row = script[i];
      if (row.kind == ROW_CFG) begin
        settle();
        write_reg(row.sel, row.data);
      end else begin
        offer(row.cmd, row.idx, row.word, row.code);
        if (row.typed) begin
          held        = pcm_expected.pop_back();
          held.sample = row.want;
          pcm_expected.push_back(held);
        end
      end
    end

    // Random phases: each one programmes every register afresh, then sends
    // mostly whole frames (all taps loaded, then a burst of residual bytes)
    // with the odd stray command mixed in.
    for (int phase = 0; phase < PHASES; phase++) begin
      settle();
      case (phase)
        0: begin
          ord = 6'd1;
          fld = 4'd1;
        end
        1: begin
          ord = 6'd32;
          fld = 4'd8;
        end
        4: begin
          ord = 6'd0;
          fld = 4'd0;
        end
        default: begin
          ord = 6'($urandom_range(0, 63));
          fld = 4'($urandom_range(0, 15));
        end
      endcase
      if (phase == 5) begin
        cmin   = 24'h800000;
        crange = 24'h7FFFFF;
      end else if (phase % 2 == 0) begin
        // Small coefficients keep the filter away from saturation.
        cmin   = 24'($urandom_range(0, 131072)) - 24'd65536;
        crange = 24'($urandom_range(0, 131072)) - 24'd65536;
      end else begin
        cmin   = 24'($urandom);
        crange = 24'($urandom);
      end
      write_reg(REG_ORDER, {18'($urandom), ord});
      write_reg(REG_COEF_MIN, cmin);
      write_reg(REG_COEF_RANGE, crange);
      write_reg(REG_FOLD, {20'($urandom), fld});
      write_reg(REG_EMPHASIS, 24'($urandom));
      write_reg(REG_CLEAR, 24'($urandom));
      write_reg((phase % 2 == 0) ? REG_SPARE_6 : REG_SPARE_7, 24'($urandom));

      quiet = (phase == 3);
      if (phase == 2) hold_request = 1'b1;

      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(0, 99) < 80) begin
          ntaps = taps_in_use();
          for (int t = 0; t < ntaps && sent < PHASE_ITEMS; t++) begin
            offer(CMD_LOAD, 5'(t), 16'($urandom), 8'($urandom));
            sent++;
          end
          nbytes = $urandom_range(2, 6);
          for (int b = 0; b < nbytes && sent < PHASE_ITEMS; b++) begin
            offer(CMD_PROCESS, 5'($urandom), 16'($urandom), 8'($urandom));
            sent++;
          end
        end else begin
          offer(cmd_e'($urandom_range(0, 1)), 5'($urandom), 16'($urandom), 8'($urandom));
          sent++;
        end
      end
      quiet = 1'b0;
    end

    settle();
    fault_count += pcm_expected.size();

    $display("Covered %0d coefficient loads and %0d residual bytes across %0d register writes,",
             loads_sent, bytes_sent, settings_written);
    $display("comparing %0d samples with %0d faults found.", samples_checked, fault_count);
    if (fault_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
